### rtl/core/tcw_pkg.sv
// Shared types, codes and constants for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = 11;
    localparam int VALUE_W     = 16;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int COLOR_W     = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_MODE  = 4'd1;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;
    localparam logic [CHAR_W-1:0]  CODE_NEWLINE     = 8'd10;
    localparam logic [CHAR_W-1:0]  CODE_BACKSPACE   = 8'd8;
    localparam logic [CHAR_W-1:0]  CODE_SPACE       = 8'd32;
    localparam logic [VALUE_W-1:0] RESET_WORD       = 16'h0720;

    typedef struct packed {
        logic load;
        logic put;
        logic home;
        logic read;
        logic ptr_clear;
        logic sweep_copy;
        logic sweep_fill;
        logic fill_init;
        logic out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            need_scroll;
        logic            ptr_last;
    } tcw_status_t;

endpackage

### rtl/core/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  tcw_status_t status,
    output tcw_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status.ptr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (status.op)
                    OP_PUT:   state_next = status.need_scroll ? ST_SCROLL : ST_RESULT;
                    OP_CLEAR: state_next = ST_CLEAR;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_SCROLL, ST_CLEAR: begin
                if (status.ptr_last) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_fill = 1'b1;
                cmd.fill_init  = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.ptr_clear = 1'b1;
                case (status.op)
                    OP_PUT:   cmd.put  = 1'b1;
                    OP_CLEAR: cmd.home = 1'b1;
                    OP_READ:  cmd.read = 1'b1;
                    default:  cmd.put  = 1'b0;
                endcase
            end
            ST_SCROLL: cmd.sweep_copy = 1'b1;
            ST_CLEAR:  cmd.sweep_fill = 1'b1;
            ST_RESULT: cmd.out_load   = !m_valid_reg || m_ready;
            default:   cmd = '0;
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);
    assign m_valid      = m_valid_reg;

endmodule

### rtl/core/tcw_datapath.sv
// Datapath of the text console writer: screen memory, cursor, sweep engine and result register.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcw_cmd_t               cmd,
    output tcw_status_t            status,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [CHAR_W-1:0]      s_char_code,
    input  logic [ADDR_W-1:0]      s_cell_address,
    output logic [VALUE_W-1:0]     m_cell_value,
    output logic [COL_W-1:0]       m_cursor_column,
    output logic [ROW_W-1:0]       m_cursor_row,
    output logic [ADDR_W-1:0]      m_cursor_linear
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = CELLS - COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);

    logic [VALUE_W-1:0] mem [CELLS];

    logic [COLOR_W-1:0] text_color_reg;
    logic               wrap_mode_reg;

    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      ptr_next;

    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [AW-1:0]      pend_addr_reg;
    logic [AW-1:0]      pend_addr_next;
    logic               pend_copy_reg;
    logic               pend_copy_next;
    logic [VALUE_W-1:0] pend_word_reg;
    logic [VALUE_W-1:0] pend_word_next;

    logic [VALUE_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic [VALUE_W-1:0] out_value_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [ADDR_W-1:0]  out_lin_reg;

    logic               is_newline;
    logic               is_backspace;
    logic               is_plain;
    logic               col_end;
    logic               row_end;
    logic               adv_row;
    logic               cell_write;
    logic [AW-1:0]      lin;
    logic [VALUE_W-1:0] addr_wide;
    logic               addr_in_range;

    assign is_newline   = char_reg == CODE_NEWLINE;
    assign is_backspace = char_reg == CODE_BACKSPACE;
    assign is_plain     = !is_newline && !is_backspace;
    assign col_end      = col_reg == CW'(COLUMNS - 1);
    assign row_end      = row_reg == RW'(ROWS - 1);
    assign adv_row      = is_newline || (is_plain && col_end);
    assign cell_write   = is_plain || (is_backspace && col_reg != '0);
    assign lin          = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign addr_wide     = VALUE_W'(addr_reg);
    assign addr_in_range = addr_wide < VALUE_W'(CELLS);

    assign status.op          = op_reg;
    assign status.need_scroll = adv_row && row_end && !wrap_mode_reg;
    assign status.ptr_last    = ptr_reg == AW'(CELLS - 1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.home) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd.put) begin
            if (is_newline) begin
                col_next = '0;
            end else if (is_backspace) begin
                if (col_reg != '0) col_next = col_reg - 1'b1;
            end else begin
                col_next = col_end ? '0 : col_reg + 1'b1;
            end
            if (adv_row) begin
                if (!row_end) begin
                    row_next = row_reg + 1'b1;
                end else if (wrap_mode_reg) begin
                    row_next = '0;
                end
            end
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_clear) begin
            ptr_next = '0;
        end else if (cmd.sweep_copy || cmd.sweep_fill) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_comb begin
        pend_valid_next = 1'b0;
        pend_addr_next  = ptr_reg;
        pend_copy_next  = 1'b0;
        pend_word_next  = '0;
        if (cmd.sweep_fill) begin
            pend_valid_next = 1'b1;
            pend_word_next  = cmd.fill_init ? RESET_WORD : '0;
        end else if (cmd.sweep_copy) begin
            pend_valid_next = 1'b1;
            pend_copy_next  = ptr_reg < AW'(COPY_CELLS);
        end else if (cmd.put && cell_write) begin
            pend_valid_next = 1'b1;
            pend_addr_next  = is_plain ? lin : lin - 1'b1;
            pend_word_next  = {text_color_reg, is_plain ? char_reg : CODE_SPACE};
        end
    end

    assign rd_en   = cmd.read || cmd.sweep_copy;
    assign rd_addr = cmd.read ? addr_wide[AW-1:0] : ptr_reg + AW'(COLUMNS);

    always_ff @(posedge aclk) begin
        if (pend_valid_reg) begin
            mem[pend_addr_reg] <= pend_copy_reg ? rd_data_reg : pend_word_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= TEXT_COLOR_RESET;
            wrap_mode_reg  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == REG_TEXT_COLOR) text_color_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_WRAP_MODE)  wrap_mode_reg  <= cfg_data[0];
            col_reg        <= col_next;
            row_reg        <= row_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
        pend_word_reg <= pend_word_next;
        if (cmd.load) begin
            op_reg   <= s_operation;
            char_reg <= s_char_code;
            addr_reg <= s_cell_address;
        end
        if (cmd.out_load) begin
            out_value_reg <= (op_reg == OP_READ && addr_in_range) ? rd_data_reg : '0;
            out_col_reg   <= COL_W'(col_reg);
            out_row_reg   <= ROW_W'(row_reg);
            out_lin_reg   <= ADDR_W'(lin);
        end
    end

    assign m_cell_value    = out_value_reg;
    assign m_cursor_column = out_col_reg;
    assign m_cursor_row    = out_row_reg;
    assign m_cursor_linear = out_lin_reg;

endmodule

### rtl/core/text_console_writer_core.sv
// Top level of the text console writer: controller, datapath and assertions.
// A put-character, read or unused-code beat is latched in the accepting cycle; the next
// one updates the cursor or issues the memory read, and the result register is then
// loaded once no earlier result is still waiting. A clear sweeps the screen memory
// through its single write port, one cell a cycle, before its result is loaded. A newline
// or a wrap past the bottom row in scroll mode copies every row up through the same port
// and zeroes the bottom row, with the same timing as a clear. After reset the block fills
// every cell with 0x0720 and accepts no beat until that pass is done; configuration
// writes are taken at any time and should only be issued while the block is idle. The
// next beat may be accepted while a result waits; that beat then holds in its last cycle
// until the waiting result is taken.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [CHAR_W-1:0]      s_char_code,
    input  logic [ADDR_W-1:0]      s_cell_address,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_W-1:0]     m_cell_value,
    output logic [COL_W-1:0]       m_cursor_column,
    output logic [ROW_W-1:0]       m_cursor_row,
    output logic [ADDR_W-1:0]      m_cursor_linear
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_operation     (s_operation),
        .s_char_code     (s_char_code),
        .s_cell_address  (s_cell_address),
        .m_cell_value    (m_cell_value),
        .m_cursor_column (m_cursor_column),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_linear (m_cursor_linear)
    );

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is still in progress");

    a_column_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_column) < COLUMNS))
        else $error("reported cursor column beyond the last column");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_row) < ROWS))
        else $error("reported cursor row beyond the last row");

    a_result_follows_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_ready)
        else $error("result loaded while the block reports idle");

endmodule
